// File: hdl/lwsm_pkg.sv
package lwsm_pkg;

  // Field widths
  localparam int ADDR_W     = 20;
  localparam int VAL_W      = 4;
  localparam int STRIDE_W   = 12;
  localparam int MLC_W      = 6;
  localparam int OUT_COL_W  = 6;
  localparam int OUT_ROW_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Menu rows have a fixed pitch in nibbles
  localparam int ROW_NIBBLES = 34;

  // Serial divider: one quotient bit per step
  localparam int DIV_BITS  = ADDR_W;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_LINE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MENU_BASE       = 2'd3;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd34;
  localparam logic [MLC_W-1:0]    MLC_RESET    = 6'd63;

  typedef struct packed {
    logic [ADDR_W-1:0]   display_base;
    logic [STRIDE_W-1:0] line_stride;
    logic [MLC_W-1:0]    main_line_count;
    logic [ADDR_W-1:0]   menu_base;
  } cfg_t;

  // Microprogram addresses
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_FETCH = 4'd0;
  localparam step_t S_CHK   = 4'd1;
  localparam step_t S_SEL   = 4'd2;
  localparam step_t S_DIV   = 4'd3;
  localparam step_t S_MAP   = 4'd4;
  localparam step_t S_LOOP  = 4'd5;
  localparam step_t S_CMP   = 4'd6;
  localparam step_t S_PUSH  = 4'd7;
  localparam step_t S_NEXT  = 4'd8;
  localparam step_t S_FLUSH = 4'd9;
  localparam step_t S_DONE  = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MAP,
    OP_READ,
    OP_PUSH,
    OP_ROW_INC,
    OP_FLUSH
  } op_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_IN,
    C_BORROW,
    C_NO_DIV,
    C_DIV_MORE,
    C_OFF_SCREEN,
    C_ROWS_DONE,
    C_SAME,
    C_PUSH_WAIT,
    C_FLUSH_WAIT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic no_in;
    logic borrow;
    logic no_div;
    logic div_more;
    logic off_screen;
    logic rows_done;
    logic same;
    logic push_wait;
    logic flush_wait;
  } flags_t;

  // Control store: jump to target when the condition holds, else fall through
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    unique case (step)
      S_FETCH: w = '{op: OP_LOAD,     cond: C_NO_IN,      target: S_FETCH};
      S_CHK:   w = '{op: OP_DIV_INIT, cond: C_BORROW,     target: S_FETCH};
      S_SEL:   w = '{op: OP_NOP,      cond: C_NO_DIV,     target: S_MAP};
      S_DIV:   w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,   target: S_DIV};
      S_MAP:   w = '{op: OP_MAP,      cond: C_OFF_SCREEN, target: S_FETCH};
      S_LOOP:  w = '{op: OP_READ,     cond: C_ROWS_DONE,  target: S_FLUSH};
      S_CMP:   w = '{op: OP_NOP,      cond: C_SAME,       target: S_NEXT};
      S_PUSH:  w = '{op: OP_PUSH,     cond: C_PUSH_WAIT,  target: S_PUSH};
      S_NEXT:  w = '{op: OP_ROW_INC,  cond: C_ALWAYS,     target: S_LOOP};
      S_FLUSH: w = '{op: OP_FLUSH,    cond: C_FLUSH_WAIT, target: S_FLUSH};
      S_DONE:  w = '{op: OP_NOP,      cond: C_ALWAYS,     target: S_FETCH};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,     target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/lcd_write_snoop_mapper.sv
// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------------
// in        in_valid / in_stall   in_command, in_address, in_value
// out       out_valid / out_stall out_column, out_row, out_pixels, out_last
// cfg       cfg_we                cfg_index, cfg_data
//
// One write at a time. A main write with a nonzero stride, or a menu write,
// runs the bit-serial divider and then the mapping step, where it is dropped
// when off screen; else the shadow is read, and the nibble is pushed when it
// changed. A zero-stride write skips the divider and reads, compares and pushes each row.
// After reset all SCREEN_ROWS * SHADOW_COLS shadow entries (2304 by default) are
// cleared with in_stall high. out_stall only delays the microprogram while a beat is held.
module lcd_write_snoop_mapper
  import lwsm_pkg::*;
#(
  parameter int SCREEN_ROWS = 64,
  parameter int SHADOW_COLS = 36
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic [VAL_W-1:0]      in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_COL_W-1:0]  out_column,
  output logic [OUT_ROW_W-1:0]  out_row,
  output logic [VAL_W-1:0]      out_pixels,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = SCREEN_ROWS * SHADOW_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  cfg_t          cfg_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;
  ctrl_t         ctrl;
  flags_t        flags;
  logic          ld;
  logic          dp_re;
  logic          dp_we;
  logic [AW-1:0] dp_addr;
  logic [VAL_W:0] dp_wdata;
  logic          ram_we;
  logic [AW-1:0] ram_wr_addr;
  logic [VAL_W:0] ram_wdata;
  logic [VAL_W:0] ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_base    <= '0;
      cfg_r.line_stride     <= STRIDE_RESET;
      cfg_r.main_line_count <= MLC_RESET;
      cfg_r.menu_base       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DISPLAY_BASE:    cfg_r.display_base    <= cfg_data[ADDR_W-1:0];
        REG_LINE_STRIDE:     cfg_r.line_stride     <= cfg_data[STRIDE_W-1:0];
        REG_MAIN_LINE_COUNT: cfg_r.main_line_count <= cfg_data[MLC_W-1:0];
        REG_MENU_BASE:       cfg_r.menu_base       <= cfg_data[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sweep the shadow to invalid after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == LAST_A) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Take a beat only at the fetch step once the sweep is done
  assign in_stall = !((ctrl.op == OP_LOAD) && !clr_busy_r);
  assign ld       = in_valid && !in_stall;

  // Shadow write port: sweep first, then the datapath
  assign ram_we      = clr_busy_r || dp_we;
  assign ram_wr_addr = clr_busy_r ? clr_cnt_r : dp_addr;
  assign ram_wdata   = clr_busy_r ? '0 : dp_wdata;

  lwsm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  lwsm_dp #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SHADOW_COLS (SHADOW_COLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .cfg        (cfg_r),
    .ld         (ld),
    .in_command (in_command),
    .in_address (in_address),
    .in_value   (in_value),
    .flags      (flags),
    .ram_re     (dp_re),
    .ram_we     (dp_we),
    .ram_addr   (dp_addr),
    .ram_wdata  (dp_wdata),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_column (out_column),
    .out_row    (out_row),
    .out_pixels (out_pixels),
    .out_last   (out_last)
  );

  lwsm_ram #(
    .WIDTH (VAL_W + 1),
    .DEPTH (DEPTH)
  ) u_shadow (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wdata),
    .re      (dp_re),
    .rd_addr (dp_addr),
    .rd_data (ram_rdata)
  );

endmodule

// File: hdl/lwsm_ram.sv
module lwsm_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 2304,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/lwsm_seq.sv
module lwsm_seq
  import lwsm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  step_t step_r;
  step_t step_nxt;
  logic  hit;

  // Fetch the control word of the current step
  assign ctrl = ucode(step_r);

  // Select the jump condition
  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:     hit = 1'b1;
      C_NO_IN:      hit = flags.no_in;
      C_BORROW:     hit = flags.borrow;
      C_NO_DIV:     hit = flags.no_div;
      C_DIV_MORE:   hit = flags.div_more;
      C_OFF_SCREEN: hit = flags.off_screen;
      C_ROWS_DONE:  hit = flags.rows_done;
      C_SAME:       hit = flags.same;
      C_PUSH_WAIT:  hit = flags.push_wait;
      C_FLUSH_WAIT: hit = flags.flush_wait;
      default:      hit = 1'b1;
    endcase
  end

  assign step_nxt = hit ? ctrl.target : step_r + step_t'(1);

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: hdl/lwsm_dp.sv
module lwsm_dp
  import lwsm_pkg::*;
#(
  parameter int SCREEN_ROWS = 64,
  parameter int SHADOW_COLS = 36,
  localparam int AW = $clog2(SCREEN_ROWS * SHADOW_COLS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_t                ctrl,
  input  cfg_t                 cfg,
  input  logic                 ld,
  input  logic                 in_command,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [VAL_W-1:0]     in_value,
  output flags_t               flags,
  output logic                 ram_re,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_addr,
  output logic [VAL_W:0]       ram_wdata,
  input  logic [VAL_W:0]       ram_rdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_COL_W-1:0] out_column,
  output logic [OUT_ROW_W-1:0] out_row,
  output logic [VAL_W-1:0]     out_pixels,
  output logic                 out_last
);

  localparam int COL_W = $clog2(SHADOW_COLS);
  localparam int ROW_W = $clog2(SCREEN_ROWS + 1);
  localparam int CE_W  = COL_W + OUT_COL_W;
  localparam int RE_W  = ROW_W + OUT_ROW_W;

  localparam logic [ADDR_W-1:0]    COLS_LIM  = ADDR_W'(SHADOW_COLS);
  localparam logic [ADDR_W:0]      ROWS_LIM  = (ADDR_W + 1)'(SCREEN_ROWS);
  localparam logic [MLC_W:0]       ROWS_MLC  = (MLC_W + 1)'(SCREEN_ROWS);
  localparam logic [ROW_W-1:0]     ROWS_CNT  = ROW_W'(SCREEN_ROWS);
  localparam logic [AW-1:0]        COLS_A    = AW'(SHADOW_COLS);
  localparam logic [STRIDE_W-1:0]  MENU_DIV  = STRIDE_W'(ROW_NIBBLES);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIV_BITS - 1);

  // Item registers
  logic                  cmd_r;
  logic [VAL_W-1:0]      val_r;
  logic [ADDR_W-1:0]     off_r;
  logic                  borrow_r;
  // Divider registers
  logic [STRIDE_W-1:0]   dsr_r;
  logic [STRIDE_W-1:0]   rem_r;
  logic [ADDR_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  // Position and row loop
  logic [COL_W-1:0]      col_r;
  logic [ROW_W-1:0]      row_r;
  logic [ROW_W-1:0]      lim_r;
  // Held event, sent once the next one or the end is known
  logic                  pend_valid_r;
  logic [COL_W-1:0]      pend_col_r;
  logic [ROW_W-1:0]      pend_row_r;
  // Output register
  logic                  out_valid_r;
  logic [OUT_COL_W-1:0]  out_col_r;
  logic [OUT_ROW_W-1:0]  out_row_r;
  logic [VAL_W-1:0]      out_pix_r;
  logic                  out_last_r;

  logic [ADDR_W-1:0]     base;
  logic [ADDR_W:0]       diff;
  logic [STRIDE_W:0]     shifted;
  logic [STRIDE_W+1:0]   trial;
  logic                  zero_mode;
  logic [ADDR_W:0]       menu_row;
  logic [ADDR_W:0]       row_wide;
  logic [ADDR_W-1:0]     col_wide;
  logic                  off_screen;
  logic [ROW_W-1:0]      zero_lim;
  logic                  out_free;
  logic                  hold_wait;
  logic                  do_push;
  logic                  do_flush;
  logic [CE_W-1:0]       col_ext;
  logic [RE_W-1:0]       row_ext;

  // Offset from the selected base; the top bit flags an address below it
  assign base = in_command ? cfg.menu_base : cfg.display_base;
  assign diff = {1'b0, in_address} - {1'b0, base};

  // Restoring divide step
  assign shifted = {rem_r, quo_r[ADDR_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};

  // Map the quotient and remainder, or the raw offset, to a position
  assign zero_mode = !cmd_r && (cfg.line_stride == '0);
  assign menu_row  = {{(ADDR_W + 1 - MLC_W){1'b0}}, cfg.main_line_count}
                     + (ADDR_W + 1)'(1) + {1'b0, quo_r};
  assign row_wide  = cmd_r ? menu_row : {1'b0, quo_r};
  assign col_wide  = zero_mode ? off_r : {{(ADDR_W - STRIDE_W){1'b0}}, rem_r};
  assign off_screen = (col_wide >= COLS_LIM) || (!zero_mode && (row_wide >= ROWS_LIM));

  // Zero stride visits rows below both the line count and the screen height
  always_comb begin
    if ({1'b0, cfg.main_line_count} >= ROWS_MLC) begin
      zero_lim = ROWS_CNT;
    end else begin
      zero_lim = ROW_W'(cfg.main_line_count);
    end
  end

  // Shadow access
  assign ram_addr  = AW'(row_r) * COLS_A + AW'(col_r);
  assign ram_re    = (ctrl.op == OP_READ);
  assign ram_we    = do_push;
  assign ram_wdata = {1'b1, val_r};

  // Output hand-off
  assign out_free  = !out_valid_r || !out_stall;
  assign hold_wait = pend_valid_r && !out_free;
  assign do_push   = (ctrl.op == OP_PUSH) && !hold_wait;
  assign do_flush  = (ctrl.op == OP_FLUSH) && !hold_wait;
  assign col_ext   = CE_W'(pend_col_r);
  assign row_ext   = RE_W'(pend_row_r);

  // Status for the sequencer
  always_comb begin
    flags.no_in      = !ld;
    flags.borrow     = borrow_r;
    flags.no_div     = zero_mode;
    flags.div_more   = (cnt_r != DIV_LAST);
    flags.off_screen = off_screen;
    flags.rows_done  = (row_r >= lim_r);
    flags.same       = ram_rdata[VAL_W] && (ram_rdata[VAL_W-1:0] == val_r);
    flags.push_wait  = hold_wait;
    flags.flush_wait = hold_wait;
  end

  // Execute the datapath operation of the current step
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (ld) begin
          cmd_r    <= in_command;
          val_r    <= in_value;
          off_r    <= diff[ADDR_W-1:0];
          borrow_r <= diff[ADDR_W];
        end
      end
      OP_DIV_INIT: begin
        rem_r <= '0;
        quo_r <= off_r;
        cnt_r <= '0;
        dsr_r <= cmd_r ? MENU_DIV : cfg.line_stride;
      end
      OP_DIV_STEP: begin
        if (!trial[STRIDE_W+1]) begin
          rem_r <= trial[STRIDE_W-1:0];
          quo_r <= {quo_r[ADDR_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[STRIDE_W-1:0];
          quo_r <= {quo_r[ADDR_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      OP_MAP: begin
        col_r <= COL_W'(col_wide);
        if (zero_mode) begin
          row_r <= '0;
          lim_r <= zero_lim;
        end else begin
          row_r <= ROW_W'(row_wide);
          lim_r <= ROW_W'(row_wide) + ROW_W'(1);
        end
      end
      OP_ROW_INC: begin
        row_r <= row_r + ROW_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Hold a changed position; release the previous one as a beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      pend_col_r <= col_r;
      pend_row_r <= row_r;
    end
    if ((do_push || do_flush) && pend_valid_r) begin
      out_col_r  <= col_ext[OUT_COL_W-1:0];
      out_row_r  <= row_ext[OUT_ROW_W-1:0];
      out_pix_r  <= val_r;
      out_last_r <= do_flush;
    end
  end

  // Valid flags of the held event and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if ((do_push || do_flush) && pend_valid_r) begin
        out_valid_r <= 1'b1;
      end
      if (do_push) begin
        pend_valid_r <= 1'b1;
      end else if (do_flush) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_column = out_col_r;
  assign out_row    = out_row_r;
  assign out_pixels = out_pix_r;
  assign out_last   = out_last_r;

endmodule

// File: sim/lcd_write_snoop_mapper_tb.sv
`timescale 1ns / 1ps

module lcd_write_snoop_mapper_tb;
  import lwsm_pkg::*;

  localparam int SCREEN_ROWS  = 64;
  localparam int SHADOW_COLS  = 36;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int HOLD_CYCLES  = 700;
  localparam int PHASE_WRITES = 50;
  localparam int MAX_PRINTS   = 40;

  localparam logic CMD_MAIN = 1'b0;
  localparam logic CMD_MENU = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  val;
  } snoop_write_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0] column;
    logic [OUT_ROW_W-1:0] row;
    logic [VAL_W-1:0]     pixels;
    logic                 last;
  } redraw_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = 1'b0;
  logic [ADDR_W-1:0]     in_address = '0;
  logic [VAL_W-1:0]      in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_COL_W-1:0]  out_column;
  logic [OUT_ROW_W-1:0]  out_row;
  logic [VAL_W-1:0]      out_pixels;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: register copy and screen shadow
  cfg_t       layout;
  logic       shadow_valid [SCREEN_ROWS][SHADOW_COLS];
  logic [3:0] shadow_nib [SCREEN_ROWS][SHADOW_COLS];

  snoop_write_t pending_writes [$];
  redraw_t      pending_redraws [$];

  int unsigned writes_queued = 0;
  int unsigned writes_taken = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off = 1'b0;

  lcd_write_snoop_mapper i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_address (in_address),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_column (out_column),
    .out_row    (out_row),
    .out_pixels (out_pixels),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Map one snooped write to the redraws it should cause, updating the shadow
  function automatic void predict_redraws(input logic cmd, input logic [ADDR_W-1:0] addr,
                                          input logic [VAL_W-1:0] val);
    redraw_t     hits [$];
    redraw_t     hit;
    int unsigned offset, col, r_lo, r_hi, row, stride;
    bit          on_map;
    on_map = 1'b1;
    col    = 0;
    r_lo   = 0;
    r_hi   = 0;
    stride = int'(layout.line_stride);
    if (cmd == CMD_MAIN) begin
      if (addr < layout.display_base) begin
        on_map = 1'b0;
      end else begin
        offset = int'(addr - layout.display_base);
        if (stride != 0) begin
          col  = offset % stride;
          r_lo = offset / stride;
          r_hi = r_lo + 1;
        end else begin
          // zero stride: same column on every main line
          col  = offset;
          r_lo = 0;
          r_hi = int'(layout.main_line_count);
        end
      end
    end else begin
      if (addr < layout.menu_base) begin
        on_map = 1'b0;
      end else begin
        offset = int'(addr - layout.menu_base);
        col    = offset % ROW_NIBBLES;
        r_lo   = int'(layout.main_line_count) + 1 + offset / ROW_NIBBLES;
        r_hi   = r_lo + 1;
      end
    end
    if (on_map && col < SHADOW_COLS) begin
      for (row = r_lo; row < r_hi && row < SCREEN_ROWS; row++) begin
        // skip a nibble that already holds this value
        if (!(shadow_valid[row][col] && shadow_nib[row][col] == val)) begin
          shadow_valid[row][col] = 1'b1;
          shadow_nib[row][col]   = val;
          hit.column = OUT_COL_W'(col);
          hit.row    = OUT_ROW_W'(row);
          hit.pixels = val;
          hit.last   = 1'b0;
          hits.push_back(hit);
        end
      end
    end
    if (hits.size() != 0) begin
      hit = hits.pop_back();
      hit.last = 1'b1;
      hits.push_back(hit);
    end
    foreach (hits[i]) pending_redraws.push_back(hits[i]);
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("ERROR %s: got %0d expected %0d at %0t", what, got_v, want_v, $time);
  endtask

  // Drive write beats from the pending queue; predict on acceptance
  always @(posedge clk) begin : drive_writes
    snoop_write_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_redraws(in_command, in_address, in_value);
        writes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_writes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          w = pending_writes.pop_front();
          in_valid   <= 1'b1;
          in_command <= w.cmd;
          in_address <= w.addr;
          in_value   <= w.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check redraw beats against the oldest expectation; drive the stall
  always @(posedge clk) begin : watch_redraws
    redraw_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_redraws.size() == 0) begin
        report_mismatch("redraw beat with nothing expected, row", int'(out_row), -1);
      end else begin
        want = pending_redraws.pop_front();
        if (out_column !== want.column)
          report_mismatch("column", int'(out_column), int'(want.column));
        if (out_row !== want.row)
          report_mismatch("row", int'(out_row), int'(want.row));
        if (out_pixels !== want.pixels)
          report_mismatch("pixels", int'(out_pixels), int'(want.pixels));
        if (out_last !== want.last)
          report_mismatch("last", int'(out_last), int'(want.last));
      end
    end
    out_stall <= hold_off || ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_DISPLAY_BASE:    layout.display_base    = data;
      REG_LINE_STRIDE:     layout.line_stride     = data[STRIDE_W-1:0];
      REG_MAIN_LINE_COUNT: layout.main_line_count = data[MLC_W-1:0];
      REG_MENU_BASE:       layout.menu_base       = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_layout(input logic [ADDR_W-1:0] base, input logic [STRIDE_W-1:0] stride,
                            input logic [MLC_W-1:0] lines, input logic [ADDR_W-1:0] menu);
    write_reg(REG_DISPLAY_BASE, base);
    write_reg(REG_LINE_STRIDE, CFG_DATA_W'(stride));
    write_reg(REG_MAIN_LINE_COUNT, CFG_DATA_W'(lines));
    write_reg(REG_MENU_BASE, menu);
  endtask

  task automatic random_layout(input bit force_zero);
    int unsigned pick, stride;
    pick = $urandom_range(99, 0);
    if (force_zero || pick < 15) stride = 0;
    else if (pick < 35) stride = ROW_NIBBLES;
    else if (pick < 65) stride = $urandom_range(40, 1);
    else stride = $urandom_range(4095, 41);
    set_layout(ADDR_W'($urandom_range(20'hBFFFF, 0)), STRIDE_W'(stride),
               MLC_W'($urandom_range(63, 1)),
               ADDR_W'($urandom_range(20'hFFFFF - 64 * ROW_NIBBLES, 0)));
  endtask

  // Hold until every write is taken, every redraw seen, and the engine settles
  task automatic wait_idle();
    while (writes_taken != writes_queued || pending_redraws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_write(input logic cmd, input int unsigned addr, input int unsigned val);
    snoop_write_t w;
    w.cmd  = cmd;
    w.addr = ADDR_W'(addr);
    w.val  = VAL_W'(val);
    pending_writes.push_back(w);
    writes_queued++;
  endtask

  // Mostly writes aimed at the visible screen, some raw noise
  task automatic queue_random_writes(input int n);
    int unsigned pick, val, row, col, stride, lines;
    for (int i = 0; i < n; i++) begin
      pick   = $urandom_range(99, 0);
      val    = $urandom_range(1, 0) ? $urandom_range(3, 0) : $urandom_range(15, 0);
      row    = $urandom_range(1, 0) ? $urandom_range(3, 0) : $urandom_range(66, 0);
      stride = int'(layout.line_stride);
      lines  = int'(layout.main_line_count);
      if (pick < 12) begin
        queue_write($urandom_range(1, 0) ? CMD_MENU : CMD_MAIN, $urandom_range(20'hFFFFF, 0), val);
      end else if (pick < 72) begin
        if (stride == 0) begin
          queue_write(CMD_MAIN, int'(layout.display_base) + $urandom_range(38, 0), val);
        end else begin
          col = $urandom_range((stride < 40) ? stride - 1 : 39, 0);
          queue_write(CMD_MAIN, int'(layout.display_base) + row * stride + col, val);
        end
      end else begin
        row = $urandom_range(64 - lines, 0);
        queue_write(CMD_MENU, int'(layout.menu_base) + row * ROW_NIBBLES + $urandom_range(33, 0),
                    val);
      end
    end
  endtask

  initial begin
    for (int r = 0; r < SCREEN_ROWS; r++)
      for (int c = 0; c < SHADOW_COLS; c++) begin
        shadow_valid[r][c] = 1'b0;
        shadow_nib[r][c]   = 4'd0;
      end
    layout.display_base    = '0;
    layout.line_stride     = STRIDE_RESET;
    layout.main_line_count = MLC_RESET;
    layout.menu_base       = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // let the shadow clear finish
    repeat (2) @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);

    // Default layout: corners, unchanged nibble, off-screen row, menu past the screen
    set_layout(20'h0, 12'd34, 6'd63, 20'h0);
    queue_write(CMD_MAIN, 0, 0);
    queue_write(CMD_MAIN, 0, 0);
    queue_write(CMD_MAIN, 0, 15);
    queue_write(CMD_MAIN, 34 * 63 + 33, 10);
    queue_write(CMD_MAIN, 34 * 64, 4);
    queue_write(CMD_MENU, 0, 6);
    wait_idle();

    // Wide stride: address below base, column limit, menu bounds
    set_layout(20'h100, 12'd40, 6'd10, 20'h80000);
    queue_write(CMD_MAIN, 'hFF, 1);
    queue_write(CMD_MAIN, 'h100 + 35, 3);
    queue_write(CMD_MAIN, 'h100 + 36, 3);
    queue_write(CMD_MENU, 'h7FFFF, 2);
    queue_write(CMD_MENU, 'h80000 + 33 + 34 * 52, 12);
    queue_write(CMD_MENU, 'h80000 + 34 * 53, 12);
    wait_idle();

    // Zero stride at the top of the address space
    set_layout(20'hFFFFF, 12'd0, 6'd62, 20'hFFFFF);
    queue_write(CMD_MAIN, 'hFFFFF, 7);
    queue_write(CMD_MAIN, 'hFFFFE, 7);
    queue_write(CMD_MENU, 'hFFFFF, 1);
    wait_idle();

    // Zero stride, all main lines, then a single line
    set_layout(20'h10, 12'd0, 6'd63, 20'h0);
    queue_write(CMD_MAIN, 'h10 + 35, 5);
    queue_write(CMD_MAIN, 'h10 + 35, 5);
    queue_write(CMD_MAIN, 'h10 + 36, 5);
    wait_idle();
    write_reg(REG_MAIN_LINE_COUNT, CFG_DATA_W'(1));
    queue_write(CMD_MAIN, 'h10 + 35, 9);
    queue_write(CMD_MENU, 0, 2);
    wait_idle();

    // Stride extremes
    set_layout(20'h0, 12'd4095, 6'd63, 20'h40000);
    queue_write(CMD_MAIN, 4095 * 3 + 5, 8);
    queue_write(CMD_MAIN, 'hFFFFF, 8);
    queue_write(CMD_MAIN, 4095 * 63 + 35, 11);
    wait_idle();
    set_layout(20'h12345, 12'd1, 6'd40, 20'h6789A);
    queue_write(CMD_MAIN, 'h12345 + 63, 13);
    queue_write(CMD_MAIN, 'h12345 + 64, 13);
    wait_idle();

    // Random phases, each with its own layout and pacing
    for (int p = 0; p < 8; p++) begin
      random_layout(p == 3);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (p == 0) begin
        // back up the result side so the input stalls
        fork
          begin
            @(posedge clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      queue_random_writes(PHASE_WRITES);
      wait_idle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
